// ===== sv/ptto_pkg.sv =====
// shared types and constants for the peer table with ttl and oldest eviction
package ptto_pkg;

   localparam int TableEntriesDef = 4;
   localparam int AddrW           = 32;
   localparam int PortW           = 16;
   localparam int TimeW           = 32;
   localparam int SlotW           = 2;
   localparam logic [TimeW-1:0] TtlReset = 32'd30000;

   typedef logic [SlotW-1:0] slot_type;

   typedef enum logic [1:0] {
      CMD_TOUCH  = 2'd0,
      CMD_FANOUT = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      RSP_TOUCH_HIT   = 3'd0,
      RSP_TOUCH_NEW   = 3'd1,
      RSP_TOUCH_EVICT = 3'd2,
      RSP_FANOUT_PEER = 3'd3,
      RSP_FANOUT_NONE = 3'd4,
      RSP_QUERY       = 3'd5,
      RSP_CLEARED     = 3'd6
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_EMIT,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic clear_table;
      logic scan_step;
      logic commit_touch;
      logic emit_step;
      logic load_single;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    scan_last;
      logic    any_live;
      logic    emit_live;
      logic    out_free;
   } dp_stat_type;

endpackage

// ===== sv/ptto_datapath.sv =====
// table storage, shared scan unit and result register
module ptto_datapath #(
   parameter int TABLE_ENTRIES = ptto_pkg::TableEntriesDef
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ptto_pkg::ctl_cmd_type      ctl,
   output ptto_pkg::dp_stat_type      stat,
   input  logic [1:0]                 req_command,
   input  logic [ptto_pkg::AddrW-1:0] req_addr,
   input  logic [ptto_pkg::PortW-1:0] req_port,
   input  logic [ptto_pkg::TimeW-1:0] req_now,
   input  logic                       csr_write,
   input  logic [ptto_pkg::TimeW-1:0] csr_value,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [ptto_pkg::SlotW-1:0] rsp_slot,
   output logic [ptto_pkg::AddrW-1:0] rsp_addr,
   output logic [ptto_pkg::PortW-1:0] rsp_port,
   output logic                       rsp_connected,
   output logic                       rsp_last
);
   import ptto_pkg::*;

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IdxW-1:0] IdxLast = IdxW'(TABLE_ENTRIES - 1);

   logic [AddrW-1:0] addr_ff [TABLE_ENTRIES];
   logic [PortW-1:0] port_ff [TABLE_ENTRIES];
   logic [TimeW-1:0] seen_ff [TABLE_ENTRIES];

   cmd_type          cmd_ff;
   logic [AddrW-1:0] key_addr_ff;
   logic [PortW-1:0] key_port_ff;
   logic [TimeW-1:0] now_ff;
   logic [TimeW-1:0] ttl_ff;

   logic [IdxW-1:0]  idx_ff, idx_in;
   logic [TABLE_ENTRIES-1:0] live_ff;
   logic             hit_ff, free_ff;
   logic [IdxW-1:0]  hit_idx_ff, free_idx_ff, old_idx_ff;
   logic [TimeW-1:0] old_seen_ff;

   logic             out_valid_ff;
   rsp_status_type   out_status_ff;
   slot_type         out_slot_ff;
   logic [AddrW-1:0] out_addr_ff;
   logic [PortW-1:0] out_port_ff;
   logic             out_conn_ff, out_last_ff;

   logic [AddrW-1:0] cur_addr;
   logic [PortW-1:0] cur_port;
   logic [TimeW-1:0] cur_seen, cur_age;
   logic             cur_live, cur_match, out_free;
   logic [IdxW-1:0]  target;
   rsp_status_type   touch_status;
   logic [TABLE_ENTRIES-1:0] live_below, live_above, live_others;

   // one entry per cycle through the shared compare unit
   always_comb begin
      cur_addr  = addr_ff[idx_ff];
      cur_port  = port_ff[idx_ff];
      cur_seen  = seen_ff[idx_ff];
      cur_age   = now_ff - cur_seen;
      cur_live  = (cur_port != '0) && (cur_age <= ttl_ff);
      cur_match = (cur_port == key_port_ff) && (cur_addr == key_addr_ff);
      out_free  = !out_valid_ff || rsp_ready;
      idx_in    = (idx_ff == IdxLast) ? '0 : idx_ff + IdxW'(1);
      if (hit_ff) begin
         target       = hit_idx_ff;
         touch_status = RSP_TOUCH_HIT;
      end else if (free_ff) begin
         target       = free_idx_ff;
         touch_status = RSP_TOUCH_NEW;
      end else begin
         target       = old_idx_ff;
         touch_status = RSP_TOUCH_EVICT;
      end
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
         live_below[j]  = live_ff[j] && (IdxW'(j) < idx_ff);
         live_above[j]  = live_ff[j] && (IdxW'(j) > idx_ff);
         live_others[j] = live_ff[j] && (IdxW'(j) != target);
      end
   end

   assign stat.cmd       = cmd_ff;
   assign stat.scan_last = (idx_ff == IdxLast);
   assign stat.any_live  = cur_live || (|live_below);
   assign stat.emit_live = live_ff[idx_ff];
   assign stat.out_free  = out_free;

   // table entries
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TABLE_ENTRIES; j++) begin
            addr_ff[j] <= '0;
            port_ff[j] <= '0;
            seen_ff[j] <= '0;
         end
      end else if (ctl.clear_table) begin
         for (int j = 0; j < TABLE_ENTRIES; j++) begin
            port_ff[j] <= '0;
         end
      end else if (ctl.commit_touch) begin
         addr_ff[target] <= key_addr_ff;
         port_ff[target] <= key_port_ff;
         seen_ff[target] <= now_ff;
      end else if (ctl.scan_step && cmd_ff == CMD_FANOUT && !cur_live) begin
         // expired entries drop out
         port_ff[idx_ff] <= '0;
      end
   end

   // item capture and scan bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TtlReset;
         idx_ff <= '0;
         cmd_ff <= CMD_TOUCH;
      end else begin
         if (csr_write) begin
            ttl_ff <= csr_value;
         end
         if (ctl.start) begin
            idx_ff <= '0;
            cmd_ff <= cmd_type'(req_command);
         end else if (ctl.scan_step || ctl.emit_step) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         key_addr_ff <= req_addr;
         key_port_ff <= req_port;
         now_ff      <= req_now;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
      end else if (ctl.scan_step) begin
         live_ff[idx_ff] <= cur_live;
         if (cur_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (cur_port == '0 && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (idx_ff == '0 || cur_seen < old_seen_ff) begin
            old_idx_ff  <= idx_ff;
            old_seen_ff <= cur_seen;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.commit_touch || ctl.load_single ||
                   (ctl.emit_step && live_ff[idx_ff])) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit_touch) begin
         out_status_ff <= touch_status;
         out_slot_ff   <= slot_type'(target);
         out_addr_ff   <= '0;
         out_port_ff   <= '0;
         // written entry is live exactly when its port is nonzero
         out_conn_ff   <= (|live_others) || (key_port_ff != '0);
         out_last_ff   <= 1'b1;
      end else if (ctl.load_single) begin
         unique case (cmd_ff)
            CMD_QUERY:  out_status_ff <= RSP_QUERY;
            CMD_FANOUT: out_status_ff <= RSP_FANOUT_NONE;
            default:    out_status_ff <= RSP_CLEARED;
         endcase
         out_slot_ff <= '0;
         out_addr_ff <= '0;
         out_port_ff <= '0;
         out_conn_ff <= (cmd_ff == CMD_QUERY) && (|live_ff);
         out_last_ff <= 1'b1;
      end else if (ctl.emit_step && live_ff[idx_ff]) begin
         out_status_ff <= RSP_FANOUT_PEER;
         out_slot_ff   <= slot_type'(idx_ff);
         out_addr_ff   <= cur_addr;
         out_port_ff   <= cur_port;
         out_conn_ff   <= 1'b1;
         out_last_ff   <= !(|live_above);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_slot      = out_slot_ff;
   assign rsp_addr      = out_addr_ff;
   assign rsp_port      = out_port_ff;
   assign rsp_connected = out_conn_ff;
   assign rsp_last      = out_last_ff;

`ifndef SYNTH
   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      ctl.commit_touch |=> out_valid_ff && out_last_ff)
      else $error("touch commit did not load a final result");
   a_single_loads: assert property (@(posedge clock) disable iff (reset)
      ctl.load_single |=> out_valid_ff && out_last_ff && out_slot_ff == '0)
      else $error("single result not loaded");
   a_peer_connected: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == RSP_FANOUT_PEER |-> out_conn_ff)
      else $error("fanout peer reported without connected");
`endif

endmodule

// ===== sv/ptto_ctrl.sv =====
// sequencing state machine for scan, commit and result walk
module ptto_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_command,
   output logic                  req_ready,
   input  ptto_pkg::dp_stat_type stat,
   output ptto_pkg::ctl_cmd_type ctl
);
   import ptto_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // nothing is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               ctl.start = 1'b1;
               if (cmd_type'(req_command) == CMD_CLEAR) begin
                  ctl.clear_table = 1'b1;
                  state_in        = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ctl.scan_step = 1'b1;
            if (stat.scan_last) begin
               unique case (stat.cmd)
                  CMD_TOUCH:  state_in = ST_COMMIT;
                  CMD_FANOUT: state_in = stat.any_live ? ST_EMIT : ST_RESP;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               ctl.commit_touch = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // dead slots are skipped without waiting on the output
            if (stat.out_free || !stat.emit_live) begin
               ctl.emit_step = 1'b1;
               if (stat.scan_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RESP: begin
            if (stat.out_free) begin
               ctl.load_single = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> state_ff != ST_IDLE)
      else $error("accepted transfer left controller idle");
   a_one_output_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.commit_touch, ctl.emit_step, ctl.load_single}))
      else $error("more than one output command");
   a_touch_commits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && stat.scan_last && stat.cmd == CMD_TOUCH
      |=> state_ff == ST_COMMIT)
      else $error("touch scan did not go to commit");
`endif

endmodule

// ===== sv/peer_table_ttl_oldest_evict_top.sv =====
// top level of the peer table with ttl expiry and oldest-entry eviction
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata: peer_addr, peer_port_in, now_ms; tuser: command
//  rsp      out  rsp_tvalid/rsp_tready  tdata: slot, dest_addr, dest_port, connected;
//                                       tuser: status; tlast: last
//  csr      in   csr_valid/csr_ready    csr_data: ttl_ms
//
// touch, query and fanout first scan every entry, one entry per cycle through the
// shared age and match compare; a fanout with live peers then walks the table to
// emit its results, and clear takes no scan.
// synchronous reset empties the table with zero addresses and times, ttl 30000.
// req_tready is low while an item is in work; a stalled result holds its register.
module peer_table_ttl_oldest_evict_top #(
   parameter int TABLE_ENTRIES = ptto_pkg::TableEntriesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // peer_addr[31:0], peer_port_in[47:32], now_ms[79:48]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // slot[1:0], dest_addr[33:2], dest_port[49:34],
                                    // connected[50], zero[55:51]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import ptto_pkg::*;

   ctl_cmd_type      ctl;
   dp_stat_type      stat;
   slot_type         rsp_slot;
   logic [AddrW-1:0] rsp_addr;
   logic [PortW-1:0] rsp_port;
   logic             rsp_connected;

   assign csr_ready = !reset;

   ptto_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_command (req_tuser),
      .req_ready   (req_tready),
      .stat        (stat),
      .ctl         (ctl)
   );

   ptto_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_command   (req_tuser),
      .req_addr      (req_tdata[31:0]),
      .req_port      (req_tdata[47:32]),
      .req_now       (req_tdata[79:48]),
      .csr_write     (csr_valid),
      .csr_value     (csr_data),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_status    (rsp_tuser),
      .rsp_slot      (rsp_slot),
      .rsp_addr      (rsp_addr),
      .rsp_port      (rsp_port),
      .rsp_connected (rsp_connected),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, rsp_connected, rsp_port, rsp_addr, rsp_slot};

endmodule
